// File: design/follow_mode_supervisor_fsm_defines.svh
// Assertion macros for the follow-mode supervisor.
// Included by the top level only; no other dependencies.
`ifndef FOLLOW_MODE_SUPERVISOR_FSM_DEFINES_SVH
`define FOLLOW_MODE_SUPERVISOR_FSM_DEFINES_SVH

`ifndef SYNTHESIS
// Condition in the current cycle implies a consequence in the same cycle.
`define FMSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("follow mode supervisor: same-cycle check failed");
// Condition in the current cycle implies a consequence in the next cycle.
`define FMSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("follow mode supervisor: next-cycle check failed");
`else
`define FMSF_ASSERT_SAME(lbl, ante, cons)
`define FMSF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/fmsf_pkg.sv
// Shared types and constants of the follow-mode supervisor.
// Used by the configuration interface and by every module; depends on nothing.
`timescale 1ns / 1ps

package fmsf_pkg;

  // Depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port widths.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_TIMEOUT     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOST_TIMEOUT     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GUIDED_MODE_CODE = 8'd3;

  // Register reset values.
  localparam logic [30:0] LINK_TIMEOUT_RST     = 31'd1000;
  localparam logic [30:0] LOCK_TIMEOUT_RST     = 31'd5000;
  localparam logic [30:0] LOST_TIMEOUT_RST     = 31'd5000;
  localparam logic [31:0] GUIDED_MODE_CODE_RST = 32'd4;

  // Supervisor states, encoded as the result codes.
  typedef enum logic [2:0] {
    ST_NOLINK    = 3'd0,
    ST_IDLE      = 3'd1,
    ST_LOCKING   = 3'd2,
    ST_FOLLOWING = 3'd3,
    ST_LOST      = 3'd4,
    ST_HOLD      = 3'd5
  } state_t;

  // Configuration register set.
  typedef struct packed {
    logic [30:0] link_timeout;
    logic [30:0] lock_timeout;
    logic [30:0] lost_timeout;
    logic [31:0] guided_mode_code;
  } cfg_t;

  // Classified update as it travels through the queue.
  typedef struct packed {
    logic [31:0] now_time;
    logic [31:0] flight_mode;
    logic        alive;
    logic        guided;
    logic        target_valid;
  } item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // Back part status exported for checking.
  typedef struct packed {
    logic        pop;
    state_t      state;
    logic [31:0] entered_at;
  } back_status_t;

endpackage

// File: design/fmsf_ifs.sv
// Handshake interfaces of the follow-mode supervisor: input, result and
// configuration channels. Depends on fmsf_pkg.
`timescale 1ns / 1ps

interface fmsf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_time;
  logic        heartbeat_seen;
  logic [31:0] heartbeat_time;
  logic [31:0] flight_mode;
  logic        target_valid;

  modport source (output valid, now_time, heartbeat_seen, heartbeat_time,
                  flight_mode, target_valid, input ready);
  modport sink (input valid, now_time, heartbeat_seen, heartbeat_time,
                flight_mode, target_valid, output ready);
endinterface

interface fmsf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] supervisor_state;

  modport source (output valid, supervisor_state, input ready);
  modport sink (input valid, supervisor_state, output ready);
endinterface

interface fmsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fmsf_pkg::CFG_INDEX_W-1:0] index;
  logic [fmsf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/follow_mode_supervisor_fsm.sv
// Follow-mode supervisor: one result per update, the state after the step.
// An accepted update passes through the two-entry queue and the result
// register before its result is on the output channel; one update per cycle
// is sustained while the output channel is ready, and back-pressure holds it.
// Reset (synchronous, active high) restores the registers to 1000, 5000,
// 5000 and 4, the state to no-link and empties the queue.
`timescale 1ns / 1ps
`include "follow_mode_supervisor_fsm_defines.svh"

module follow_mode_supervisor_fsm (
  input logic        clk,
  input logic        rst,
  fmsf_in_if.sink    in_ch,
  fmsf_out_if.source out_ch,
  fmsf_cfg_if.sink   cfg
);

  fmsf_pkg::cfg_t          cfg_regs;
  fmsf_pkg::queue_status_t q_status;
  fmsf_pkg::item_t         front_item;
  fmsf_pkg::item_t         queue_item;
  fmsf_pkg::back_status_t  back_status;
  logic                    push;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.link_timeout     <= fmsf_pkg::LINK_TIMEOUT_RST;
      cfg_regs.lock_timeout     <= fmsf_pkg::LOCK_TIMEOUT_RST;
      cfg_regs.lost_timeout     <= fmsf_pkg::LOST_TIMEOUT_RST;
      cfg_regs.guided_mode_code <= fmsf_pkg::GUIDED_MODE_CODE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        fmsf_pkg::REG_LINK_TIMEOUT:     cfg_regs.link_timeout     <= cfg.data[30:0];
        fmsf_pkg::REG_LOCK_TIMEOUT:     cfg_regs.lock_timeout     <= cfg.data[30:0];
        fmsf_pkg::REG_LOST_TIMEOUT:     cfg_regs.lost_timeout     <= cfg.data[30:0];
        fmsf_pkg::REG_GUIDED_MODE_CODE: cfg_regs.guided_mode_code <= cfg.data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Front part: accept and classify.
  fmsf_front u_front (
    .in_ch    (in_ch),
    .cfg_regs (cfg_regs),
    .q_status (q_status),
    .push     (push),
    .item     (front_item)
  );

  // Queue between the two parts.
  fmsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (back_status.pop),
    .rd_item (queue_item),
    .status  (q_status)
  );

  // Back part: state machine and result register.
  fmsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_status (q_status),
    .item     (queue_item),
    .out_ch   (out_ch),
    .status   (back_status)
  );

  // Every update taken by the back part shows up as a result next cycle.
  `FMSF_ASSERT_NEXT(a_pop_gives_result, back_status.pop, out_ch.valid)
  // The queue only fills up behind a result that is waiting.
  `FMSF_ASSERT_SAME(a_full_means_stalled, q_status.full, out_ch.valid)
  // The entry time moves only together with a state change.
  `FMSF_ASSERT_SAME(a_entry_time_on_change,
    back_status.entered_at != $past(back_status.entered_at),
    back_status.state != $past(back_status.state))
  // A new state is only taken when an update was consumed.
  `FMSF_ASSERT_NEXT(a_state_needs_pop, !back_status.pop,
    back_status.state == $past(back_status.state))

endmodule

// File: design/fmsf_front.sv
// Front part: accepts updates and classifies link health and mode.
// Depends on fmsf_pkg and fmsf_in_if.
`timescale 1ns / 1ps

module fmsf_front (
  fmsf_in_if.sink                 in_ch,
  input  fmsf_pkg::cfg_t          cfg_regs,
  input  fmsf_pkg::queue_status_t q_status,
  output logic                    push,
  output fmsf_pkg::item_t         item
);

  logic [31:0] hb_age;
  logic        hb_fresh;

  // Accept whenever the queue has room.
  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  // Heartbeat age as a signed difference; negative counts as fresh.
  assign hb_age   = in_ch.now_time - in_ch.heartbeat_time;
  assign hb_fresh = hb_age[31] || (hb_age[30:0] <= cfg_regs.link_timeout);

  // Classified record for the back part.
  always_comb begin
    item.now_time     = in_ch.now_time;
    item.flight_mode  = in_ch.flight_mode;
    item.alive        = in_ch.heartbeat_seen && hb_fresh;
    item.guided       = (in_ch.flight_mode == cfg_regs.guided_mode_code);
    item.target_valid = in_ch.target_valid;
  end

endmodule

// File: design/fmsf_queue.sv
// Short FIFO between the front and back parts of the supervisor.
// Depends on fmsf_pkg.
`timescale 1ns / 1ps

module fmsf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  fmsf_pkg::item_t         wr_item,
  input  logic                    pop,
  output fmsf_pkg::item_t         rd_item,
  output fmsf_pkg::queue_status_t status
);

  fmsf_pkg::item_t                 mem [fmsf_pkg::QUEUE_DEPTH];
  logic [fmsf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [fmsf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [fmsf_pkg::QPTR_W:0]       count;

  localparam logic [fmsf_pkg::QPTR_W-1:0] LAST_PTR =
    fmsf_pkg::QPTR_W'(fmsf_pkg::QUEUE_DEPTH - 1);
  localparam logic [fmsf_pkg::QPTR_W:0] FULL_COUNT =
    (fmsf_pkg::QPTR_W + 1)'(fmsf_pkg::QUEUE_DEPTH);

  assign status.not_empty = (count != '0);
  assign status.full      = (count == FULL_COUNT);
  assign rd_item          = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/fmsf_back.sv
// Back part: supervisor state machine, timeouts and the result register.
// Depends on fmsf_pkg and fmsf_out_if.
`timescale 1ns / 1ps

module fmsf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  fmsf_pkg::cfg_t          cfg_regs,
  input  fmsf_pkg::queue_status_t q_status,
  input  fmsf_pkg::item_t         item,
  fmsf_out_if.source              out_ch,
  output fmsf_pkg::back_status_t  status
);

  fmsf_pkg::state_t state;
  fmsf_pkg::state_t state_next;
  logic [31:0]      entered_at;
  logic             prior_mode_valid;
  logic [31:0]      prior_mode;
  logic             out_valid;
  fmsf_pkg::state_t out_state;

  logic             pop;
  logic [31:0]      elapsed;
  logic [30:0]      timeout;
  logic             timeout_hit;
  logic             became_guided;

  // Take the next update when the result register is free or draining.
  assign pop = q_status.not_empty && (!out_valid || out_ch.ready);

  // Time in the current state against the lock or lost limit.
  assign elapsed     = item.now_time - entered_at;
  assign timeout     = (state == fmsf_pkg::ST_LOST) ? cfg_regs.lost_timeout
                                                    : cfg_regs.lock_timeout;
  assign timeout_hit = !elapsed[31] && (elapsed[30:0] >= timeout);

  assign became_guided = item.guided && prior_mode_valid &&
                         (prior_mode != cfg_regs.guided_mode_code);

  // Next-state decode.
  always_comb begin
    state_next = state;
    if (!item.alive) begin
      state_next = fmsf_pkg::ST_NOLINK;
    end else begin
      case (state)
        fmsf_pkg::ST_NOLINK: begin
          state_next = fmsf_pkg::ST_IDLE;
        end
        fmsf_pkg::ST_IDLE: begin
          if (became_guided) begin
            state_next = fmsf_pkg::ST_LOCKING;
          end
        end
        fmsf_pkg::ST_LOCKING: begin
          if (!item.guided) begin
            state_next = fmsf_pkg::ST_IDLE;
          end else if (item.target_valid) begin
            state_next = fmsf_pkg::ST_FOLLOWING;
          end else if (timeout_hit) begin
            state_next = fmsf_pkg::ST_LOST;
          end
        end
        fmsf_pkg::ST_FOLLOWING: begin
          if (!item.guided) begin
            state_next = fmsf_pkg::ST_IDLE;
          end else if (!item.target_valid) begin
            state_next = fmsf_pkg::ST_LOST;
          end
        end
        fmsf_pkg::ST_LOST: begin
          if (!item.guided) begin
            state_next = fmsf_pkg::ST_IDLE;
          end else if (item.target_valid) begin
            state_next = fmsf_pkg::ST_FOLLOWING;
          end else if (timeout_hit) begin
            state_next = fmsf_pkg::ST_HOLD;
          end
        end
        fmsf_pkg::ST_HOLD: begin
          if (!item.guided) begin
            state_next = fmsf_pkg::ST_IDLE;
          end
        end
        default: begin
          state_next = fmsf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // State, entry time and previous mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= fmsf_pkg::ST_NOLINK;
      entered_at       <= '0;
      prior_mode_valid <= 1'b0;
      prior_mode       <= '0;
    end else if (pop) begin
      if (state_next != state) begin
        state      <= state_next;
        entered_at <= item.now_time;
      end
      prior_mode_valid <= item.alive;
      if (item.alive) begin
        prior_mode <= item.flight_mode;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_state <= state_next;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.supervisor_state = out_state;

  assign status.pop        = pop;
  assign status.state      = state;
  assign status.entered_at = entered_at;

endmodule
